[hw/rtl/gptu_pkg.sv]
// gptu_pkg: shared types, codes and constants of the packed tag unpacker
`default_nettype none

package gptu_pkg;

	// default widths and depths
	localparam int ADDR_BITS_DEF   = 16;
	localparam int QUEUE_DEPTH_DEF = 2;

	// configuration register indexes
	localparam logic [1:0] CFG_START = 2'd0;
	localparam logic [1:0] CFG_BYTES = 2'd1;

	// result kinds
	localparam logic [1:0] KIND_WRITE    = 2'd0;
	localparam logic [1:0] KIND_END      = 2'd1;
	localparam logic [1:0] KIND_END_MODE = 2'd2;

	// tag data formats
	localparam logic [1:0] FLG_PACKED  = 2'd0;
	localparam logic [1:0] FLG_REGLIST = 2'd1;
	localparam logic [1:0] FLG_IMAGE   = 2'd2;

	// graphics register numbers
	localparam logic [7:0] REG_PRIM  = 8'h00;
	localparam logic [7:0] REG_RGBAQ = 8'h01;
	localparam logic [7:0] REG_ST    = 8'h02;
	localparam logic [7:0] REG_UV    = 8'h03;
	localparam logic [7:0] REG_XYZF2 = 8'h04;
	localparam logic [7:0] REG_XYZ2  = 8'h05;
	localparam logic [7:0] REG_TEX0  = 8'h06;
	localparam logic [7:0] REG_XYZF3 = 8'h0C;
	localparam logic [7:0] REG_XYZ3  = 8'h0D;

	// packed register descriptors
	typedef enum logic [3:0] {
		D_PRIM  = 4'h0,
		D_RGBAQ = 4'h1,
		D_ST    = 4'h2,
		D_UV    = 4'h3,
		D_XYZF  = 4'h4,
		D_XYZ   = 4'h5,
		D_TEX0  = 4'h6,
		D_AD    = 4'hE,
		D_NOP   = 4'hF
	} desc_t;

	// what the front hands to the back
	typedef enum logic [1:0] {
		CMD_DATA     = 2'd0,
		CMD_PRIM     = 2'd1,
		CMD_END      = 2'd2,
		CMD_END_MODE = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t        cmd;
		desc_t       desc;
		logic [31:0] w3;
		logic [31:0] w2;
		logic [31:0] w1;
		logic [31:0] w0;
		logic [31:0] q;
		logic [15:0] addr;
	} entry_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  reg_addr;
		logic [63:0] reg_data;
		logic [15:0] src_address;
	} result_t;

endpackage

`default_nettype wire

[hw/rtl/gif_packed_tag_unpacker.sv]
// gif_packed_tag_unpacker: top level of the packed-mode tag unpacker
//
//  channel   direction  handshake        payload
//  input     in         push / full      word0 word1 word2 word3
//  result    out        empty / pop      kind reg_addr reg_data src_address
//  config    in         cfg_we           cfg_idx cfg_wdata
//
// One quadword is taken every cycle while full is low; the front updates the tag
// and loop state in the cycle of acceptance, and a result passes through the mid
// queue and then the result queue before it reaches the ports.
// The front and back meet at a QUEUE_DEPTH-entry queue; results wait in a
// second queue of the same depth, so full rises only when both queues back up.
// Reset clears both queues and loads the start address and byte budget as zero.
// A configuration write to the start address or byte budget restarts parsing from the first tag.
`default_nettype none

module gif_packed_tag_unpacker
	import gptu_pkg::*;
#(
	parameter int ADDR_BITS   = ADDR_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_idx,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        push,
	output logic             full,
	input  wire logic [31:0] word0,
	input  wire logic [31:0] word1,
	input  wire logic [31:0] word2,
	input  wire logic [31:0] word3,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       kind,
	output logic [7:0]       reg_addr,
	output logic [63:0]      reg_data,
	output logic [15:0]      src_address
);

	logic    in_acc;
	logic    fq_push;
	entry_t  fq_entry;
	entry_t  bq_entry;
	logic    bq_empty;
	logic    bq_take;
	logic    rq_full;
	logic    rq_push;
	result_t rq_res;
	result_t out_res;

	assign in_acc = push && !full;

	// front: parse and classify
	gptu_front #(
		.ADDR_BITS(ADDR_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_acc),
		.word0    (word0),
		.word1    (word1),
		.word2    (word2),
		.word3    (word3),
		.q_push   (fq_push),
		.q_entry  (fq_entry)
	);

	// queue between front and back; its full flag stalls the input
	gptu_fifo #(
		.WIDTH($bits(entry_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (fq_push),
		.wr_data(fq_entry),
		.full   (full),
		.rd_en  (bq_take),
		.rd_data(bq_entry),
		.empty  (bq_empty)
	);

	// back: build results
	gptu_back u_back (
		.ent_valid(!bq_empty),
		.ent      (bq_entry),
		.ent_take (bq_take),
		.res_full (rq_full),
		.res_push (rq_push),
		.res      (rq_res)
	);

	// result queue
	gptu_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (rq_push),
		.wr_data(rq_res),
		.full   (rq_full),
		.rd_en  (pop),
		.rd_data(out_res),
		.empty  (empty)
	);

	// result ports
	assign kind        = out_res.kind;
	assign reg_addr    = out_res.reg_addr;
	assign reg_data    = out_res.reg_data;
	assign src_address = out_res.src_address;

endmodule

`default_nettype wire

[hw/rtl/gptu_fifo.sv]
// gptu_fifo: small register queue with first-word fall-through read
`default_nettype none

module gptu_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	// status and handshake
	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(do_rd && !do_wr) |=> (count_q == $past(count_q) - 1'b1))
		else $error("queue count did not drop on read");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not rise on write");

endmodule

`default_nettype wire

[hw/rtl/gptu_front.sv]
// gptu_front: tag parsing, loop tracking and item classification
`default_nettype none

module gptu_front
	import gptu_pkg::*;
#(
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_idx,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        in_valid,
	input  wire logic [31:0] word0,
	input  wire logic [31:0] word1,
	input  wire logic [31:0] word2,
	input  wire logic [31:0] word3,
	output logic             q_push,
	output entry_t           q_entry
);

	// configuration and parse state
	logic [15:0]          start_q;
	logic [15:0]          budget_q;
	logic                 expect_tag_q;
	logic [14:0]          loops_q;
	logic [3:0]           idx_q;
	logic [3:0]           cnt_q;
	logic [63:0]          descs_q;
	logic [31:0]          heldq_q;
	logic [ADDR_BITS-1:0] cur_addr_q;
	logic [15:0]          bytes_left_q;
	logic                 stopped_q;

	// tag fields
	logic [14:0] nloop;
	logic        pre;
	logic [10:0] prim;
	logic [1:0]  flg;
	logic [3:0]  nreg;
	logic [18:0] lp;
	logic [22:0] size;
	logic        tag_end;
	logic        tag_mode;

	// data item fields
	desc_t       desc;
	logic [3:0]  idx_inc;
	logic        row_done;
	logic        work;

	assign work  = in_valid && !stopped_q;

	// tag decode and data size
	assign nloop = word0[14:0];
	assign pre   = word1[14];
	assign prim  = word1[25:15];
	assign flg   = word1[27:26];
	assign nreg  = word1[31:28];
	assign lp    = 19'(nloop) * 19'(nreg);

	always_comb begin
		case (flg)
			FLG_PACKED:  size = {lp, 4'b0000};
			FLG_REGLIST: size = {1'b0, lp, 3'b000};
			FLG_IMAGE:   size = {4'b0000, nloop, 4'b0000};
			default:     size = '0;
		endcase
	end

	assign tag_end  = (size == '0) || (size > 23'(bytes_left_q));
	assign tag_mode = (flg != FLG_PACKED);

	// descriptor walk
	assign desc     = desc_t'(descs_q[{idx_q, 2'b00} +: 4]);
	assign idx_inc  = idx_q + 1'b1;
	assign row_done = (idx_inc >= cnt_q);

	// classify into a queue entry
	always_comb begin
		q_entry      = '0;
		q_entry.addr = 16'(cur_addr_q);
		q_entry.w0   = word0;
		q_entry.w1   = word1;
		q_entry.w2   = word2;
		q_entry.w3   = word3;
		q_entry.q    = heldq_q;
		q_entry.desc = desc;
		q_push       = 1'b0;
		if (expect_tag_q) begin
			if (tag_end) begin
				q_entry.cmd = CMD_END;
				q_push      = work;
			end else if (tag_mode) begin
				q_entry.cmd = CMD_END_MODE;
				q_push      = work;
			end else begin
				q_entry.cmd = CMD_PRIM;
				q_entry.w0  = 32'(prim);
				q_push      = work && pre;
			end
		end else begin
			q_entry.cmd = CMD_DATA;
			q_push      = work && (desc inside {D_PRIM, D_RGBAQ, D_ST, D_UV, D_XYZF,
				D_XYZ, D_TEX0, D_AD});
		end
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q      <= '0;
			budget_q     <= '0;
			expect_tag_q <= 1'b1;
			loops_q      <= '0;
			idx_q        <= '0;
			cnt_q        <= '0;
			descs_q      <= '0;
			heldq_q      <= '0;
			cur_addr_q   <= '0;
			bytes_left_q <= '0;
			stopped_q    <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_idx == CFG_START || cfg_idx == CFG_BYTES) begin
				expect_tag_q <= 1'b1;
				loops_q      <= '0;
				idx_q        <= '0;
				cnt_q        <= '0;
				descs_q      <= '0;
				heldq_q      <= '0;
				stopped_q    <= 1'b0;
			end
			if (cfg_idx == CFG_START) begin
				start_q      <= cfg_wdata;
				cur_addr_q   <= ADDR_BITS'(cfg_wdata);
				bytes_left_q <= budget_q;
			end else if (cfg_idx == CFG_BYTES) begin
				budget_q     <= cfg_wdata;
				cur_addr_q   <= ADDR_BITS'(start_q);
				bytes_left_q <= cfg_wdata;
			end
		end else if (work) begin
			cur_addr_q <= cur_addr_q + ADDR_BITS'(16);
			if (expect_tag_q) begin
				if (tag_end || tag_mode) begin
					stopped_q <= 1'b1;
				end else begin
					bytes_left_q <= bytes_left_q - size[15:0];
					loops_q      <= nloop;
					cnt_q        <= nreg;
					idx_q        <= '0;
					descs_q      <= {word3, word2};
					expect_tag_q <= 1'b0;
				end
			end else begin
				if (row_done) begin
					idx_q   <= '0;
					loops_q <= loops_q - 1'b1;
					if (loops_q == 15'd1) begin
						expect_tag_q <= 1'b1;
					end
				end else begin
					idx_q <= idx_inc;
				end
				if (desc == D_ST) begin
					heldq_q <= word2;
				end
			end
		end
	end

	// checks
	a_quiet_when_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> !q_push)
		else $error("item queued after the packet end");

	a_end_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && !cfg_we && (q_entry.cmd == CMD_END || q_entry.cmd == CMD_END_MODE))
		|=> stopped_q)
		else $error("end item did not stop parsing");

	a_loop_armed: assert property (@(posedge clk) disable iff (!arst_n)
		!expect_tag_q |-> (loops_q != '0 && cnt_q != '0))
		else $error("data phase with an empty loop");

endmodule

`default_nettype wire

[hw/rtl/gptu_back.sv]
// gptu_back: formats queued items into register writes and end markers
`default_nettype none

module gptu_back
	import gptu_pkg::*;
(
	input  wire logic   ent_valid,
	input  wire entry_t ent,
	output logic        ent_take,
	input  wire logic   res_full,
	output logic        res_push,
	output result_t     res
);

	// move an item whenever the result queue has room
	assign ent_take = ent_valid && !res_full;
	assign res_push = ent_take;

	// result formatting
	always_comb begin
		res             = '0;
		res.src_address = ent.addr;
		res.kind        = KIND_WRITE;
		case (ent.cmd)
			CMD_END: begin
				res.kind = KIND_END;
			end
			CMD_END_MODE: begin
				res.kind = KIND_END_MODE;
			end
			CMD_PRIM: begin
				res.reg_addr = REG_PRIM;
				res.reg_data = 64'(ent.w0);
			end
			default: begin
				res.reg_data = {ent.w1, ent.w0};
				case (ent.desc)
					D_PRIM: res.reg_addr = REG_PRIM;
					D_RGBAQ: begin
						res.reg_addr = REG_RGBAQ;
						res.reg_data = {ent.q, ent.w3[7:0], ent.w2[7:0], ent.w1[7:0],
							ent.w0[7:0]};
					end
					D_ST: res.reg_addr = REG_ST;
					D_UV: begin
						res.reg_addr = REG_UV;
						res.reg_data = {33'b0, ent.w1[14:0], 1'b0, ent.w0[14:0]};
					end
					D_XYZF: begin
						res.reg_addr = ent.w3[15] ? REG_XYZF3 : REG_XYZF2;
						res.reg_data = {ent.w3[11:4], ent.w2[27:4], ent.w1[15:0],
							ent.w0[15:0]};
					end
					D_XYZ: begin
						res.reg_addr = ent.w3[15] ? REG_XYZ3 : REG_XYZ2;
						res.reg_data = {ent.w2, ent.w1[15:0], ent.w0[15:0]};
					end
					D_TEX0: res.reg_addr = REG_TEX0;
					D_AD: res.reg_addr = ent.w2[7:0];
					default: res.reg_addr = REG_PRIM;
				endcase
			end
		endcase
	end

endmodule

`default_nettype wire
